// ----- src/tandem_queue_departure_times_unit_macros.svh -----
// Assertion macros for the checker of the departure-time block
`ifndef TANDEM_QUEUE_DEPARTURE_TIMES_UNIT_MACROS_SVH
`define TANDEM_QUEUE_DEPARTURE_TIMES_UNIT_MACROS_SVH

// check a property on every clock edge outside reset
`define TQDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define TQDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/tqdt_pkg.sv -----
// Types and constants of the tandem queue departure-time block
package tqdt_pkg;

  localparam int TIME_W    = 48;
  localparam int SVC_W     = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_FIRST  = 1'b0,
    REG_BUFFER_SECOND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SVC_W-1:0] service_one;
    logic [SVC_W-1:0] service_two;
    logic [SVC_W-1:0] service_three;
    logic             new_run;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] depart_one;
    logic [TIME_W-1:0] depart_two;
    logic [TIME_W-1:0] depart_three;
    logic              overflow;
  } out_word_t;

  // previous departures and look-back values handed to the datapath
  typedef struct packed {
    logic [TIME_W-1:0] last_one;
    logic [TIME_W-1:0] last_two;
    logic [TIME_W-1:0] last_three;
    logic [TIME_W-1:0] look_two;
    logic [TIME_W-1:0] look_three;
  } history_t;

endpackage

// ----- src/tqdt_calc.sv -----
// Departure-time datapath: saturating adds and blocking compares of one job
module tqdt_calc
  import tqdt_pkg::*;
(
  input  in_word_t  job,
  input  history_t  hist,
  output out_word_t res
);

  logic [TIME_W:0]   sum_one, sum_two, sum_three;
  logic [TIME_W-1:0] done_one, done_two;
  logic [TIME_W-1:0] d1, start_two, d2, start_three, d3;

  always_comb begin
    // stage one: own completion, then held by stage two further down
    sum_one  = {1'b0, hist.last_one} + {{(TIME_W+1-SVC_W){1'b0}}, job.service_one};
    done_one = sum_one[TIME_W] ? TIME_MAX : sum_one[TIME_W-1:0];
    d1       = (done_one > hist.look_two) ? done_one : hist.look_two;

    // stage two: wait for own previous departure, then blocked by stage three
    start_two = (hist.last_two > d1) ? hist.last_two : d1;
    sum_two   = {1'b0, start_two} + {{(TIME_W+1-SVC_W){1'b0}}, job.service_two};
    done_two  = sum_two[TIME_W] ? TIME_MAX : sum_two[TIME_W-1:0];
    d2        = (done_two > hist.look_three) ? done_two : hist.look_three;

    // stage three: never blocked
    start_three = (hist.last_three > d2) ? hist.last_three : d2;
    sum_three   = {1'b0, start_three} + {{(TIME_W+1-SVC_W){1'b0}}, job.service_three};
    d3          = sum_three[TIME_W] ? TIME_MAX : sum_three[TIME_W-1:0];

    res.depart_one   = d1;
    res.depart_two   = d2;
    res.depart_three = d3;
    res.overflow     = sum_one[TIME_W] | sum_two[TIME_W] | sum_three[TIME_W];
  end

endmodule

// ----- src/tandem_queue_departure_times_unit.sv -----
// Top level of the tandem queue departure-time block
//
// Each input word is one job: three service times (unsigned 16.16) and a
// new_run flag that starts a fresh run. Each job gives exactly one output
// word with its departure times from the three stages (unsigned 32.16) and
// a flag that is high when any sum saturated at the top value.
// Channels use valid/stall: a word moves on a rising edge with valid high
// and stall low. The configuration port writes buffer_first (index 0) and
// buffer_second (index 1) on any edge with cfg_wr_en high; write only when
// the block is idle. Values of 0 act as 1, values above MAX_BUFFER as
// MAX_BUFFER.
// An accepted job goes into the compute register, then the output register.
// Throughput is one job per cycle while the output does not stall, set by the
// single read-modify-write of the two history rings (one read and one write
// port each); distance-one look-backs come from the last-departure registers.
// Reset clears the pipeline, the ring pointer and the run length; the rings
// themselves need no clearing, as entries before the run start read as zero.
// A stalled output holds its word; the input stalls only when the job in
// flight cannot move into the output register.
module tandem_queue_departure_times_unit
  import tqdt_pkg::*;
#(
  parameter int MAX_BUFFER = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW   = $clog2(MAX_BUFFER);
  localparam int SW   = $clog2(MAX_BUFFER + 1);
  localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;

  function automatic logic [SW-1:0] clamp_buf(input logic [CFG_W-1:0] v);
    logic [CMPW-1:0] ext;
    ext = CMPW'(v);
    if (ext == '0) begin
      return SW'(1);
    end else if (ext > CMPW'(MAX_BUFFER)) begin
      return SW'(MAX_BUFFER);
    end else begin
      return ext[SW-1:0];
    end
  endfunction

  function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] slot,
                                              input logic [SW-1:0] span);
    logic [SW-1:0] s;
    logic [SW-1:0] d;
    s = SW'(slot);
    if (s >= span) begin
      d = s - span;
    end else begin
      d = s + SW'(MAX_BUFFER) - span;
    end
    return d[AW-1:0];
  endfunction

  // history rings
  logic [TIME_W-1:0] ring_two   [MAX_BUFFER];
  logic [TIME_W-1:0] ring_three [MAX_BUFFER];

  logic [CFG_W-1:0]  buf_first_r, buf_second_r;
  logic [SW-1:0]     b1, b2;

  // issue side
  logic              accept;
  logic [AW-1:0]     iss_slot_r, slot_cur, slot_nxt;
  logic [SW-1:0]     iss_seen_r, seen_cur, seen_nxt;
  logic [AW-1:0]     rd_addr_two, rd_addr_three;

  // compute stage
  logic              c_valid_r, c_fire;
  in_word_t          c_job_r;
  logic [AW-1:0]     c_slot_r;
  logic              c_ok_two_r, c_ok_three_r, c_near_two_r, c_near_three_r;
  logic [TIME_W-1:0] rd_two_r, rd_three_r;
  logic [TIME_W-1:0] last_one_r, last_two_r, last_three_r;
  history_t          hist;
  out_word_t         res;

  // output register
  logic              out_valid_r;
  out_word_t         out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_first_r  <= CFG_W'(1);
      buf_second_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BUFFER_FIRST:  buf_first_r  <= cfg_data;
        REG_BUFFER_SECOND: buf_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b1 = clamp_buf(buf_first_r);
    b2 = clamp_buf(buf_second_r);

    c_fire   = c_valid_r && (!out_valid_r || !out_stall);
    in_stall = c_valid_r && !c_fire;
    accept   = in_valid && !in_stall;

    slot_cur = in_data.new_run ? '0 : iss_slot_r;
    seen_cur = in_data.new_run ? '0 : iss_seen_r;
    slot_nxt = (slot_cur == AW'(MAX_BUFFER - 1)) ? '0 : slot_cur + 1'b1;
    seen_nxt = (seen_cur == SW'(MAX_BUFFER)) ? seen_cur : seen_cur + 1'b1;

    rd_addr_two   = back_slot(slot_cur, b1);
    rd_addr_three = back_slot(slot_cur, b2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_slot_r <= '0;
      iss_seen_r <= '0;
      c_valid_r  <= 1'b0;
    end else if (accept) begin
      iss_slot_r <= slot_nxt;
      iss_seen_r <= seen_nxt;
      c_valid_r  <= 1'b1;
    end else if (c_fire) begin
      c_valid_r  <= 1'b0;
    end
  end

  // job payload and ring reads; read data holds while the job waits
  always_ff @(posedge clk) begin
    if (accept) begin
      c_job_r        <= in_data;
      c_slot_r       <= slot_cur;
      c_ok_two_r     <= (seen_cur >= b1);
      c_ok_three_r   <= (seen_cur >= b2);
      c_near_two_r   <= (b1 == SW'(1));
      c_near_three_r <= (b2 == SW'(1));
      rd_two_r       <= ring_two[rd_addr_two];
      rd_three_r     <= ring_three[rd_addr_three];
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      ring_two[c_slot_r]   <= res.depart_two;
      ring_three[c_slot_r] <= res.depart_three;
    end
  end

  always_comb begin
    hist.last_one   = c_job_r.new_run ? '0 : last_one_r;
    hist.last_two   = c_job_r.new_run ? '0 : last_two_r;
    hist.last_three = c_job_r.new_run ? '0 : last_three_r;
    // the previous job may still be in the ring write; take it from its register
    if (!c_ok_two_r) begin
      hist.look_two = '0;
    end else if (c_near_two_r) begin
      hist.look_two = last_two_r;
    end else begin
      hist.look_two = rd_two_r;
    end
    if (!c_ok_three_r) begin
      hist.look_three = '0;
    end else if (c_near_three_r) begin
      hist.look_three = last_three_r;
    end else begin
      hist.look_three = rd_three_r;
    end
  end

  tqdt_calc u_calc (
    .job  (c_job_r),
    .hist (hist),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_one_r   <= '0;
      last_two_r   <= '0;
      last_three_r <= '0;
    end else if (c_fire) begin
      last_one_r   <= res.depart_one;
      last_two_r   <= res.depart_two;
      last_three_r <= res.depart_three;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- src/tqdt_checker.sv -----
// Port-level checker for the departure-time block, with its bind
`include "tandem_queue_departure_times_unit_macros.svh"

module tqdt_checker
  import tqdt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  `TQDT_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "output word valid after reset")
  `TQDT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output word changed")
  `TQDT_ASSERT(a_two_after_one, out_valid |-> out_data.depart_two >= out_data.depart_one, "stage two departs before stage one")
  `TQDT_ASSERT(a_three_after_two, out_valid |-> out_data.depart_three >= out_data.depart_two, "stage three departs before stage two")

endmodule

bind tandem_queue_departure_times_unit tqdt_checker u_tqdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
